### hdl/srp_pkg.sv
package srp_pkg;

    // Default number of extra fraction bits below the 1/256 degree unit.
    localparam int FRAC_BITS_DEF = 16;

    // Width of the frame length, which is also the divisor of the slope division.
    localparam int DIVISOR_W = 16;

    // Pulse count for an angle of zero.
    localparam logic [11:0] PULSE_CENTER = 12'd1920;

    typedef enum logic {
        OP_TICK     = 1'b0,
        OP_SETPOINT = 1'b1
    } op_t;

endpackage

### hdl/servo_ramp_pwm_generator_unit.sv
// Channel  Handshake            Payload
// -------  -------------------  ------------------------------------------
// in       in_valid / in_ready  opcode, target_x, target_y, frame_ticks
// out      out_valid/ out_ready pulse_x, pulse_y (one request per tick)
//
// A tick runs a bit-serial addition of both axes and then a write-back state;
// no new item is taken until the tick has returned to idle.
// A setpoint runs both slope divisions in parallel, one quotient bit per cycle,
// and the next item is taken only once both dividers are done.
// Reset clears positions, goals and slopes to zero; no clearing pass is needed.
// A stalled output holds the write-back of the next tick and with it further input;
// until then, inputs are taken while a result waits.
module servo_ramp_pwm_generator_unit #(
    parameter int FRAC_BITS = srp_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    input  logic signed [15:0] target_x,
    input  logic signed [15:0] target_y,
    input  logic [15:0]        frame_ticks,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [11:0]        pulse_x,
    output logic [11:0]        pulse_y
);
    import srp_pkg::*;

    localparam int P  = 17 + FRAC_BITS;   // position width
    localparam int Q  = 16 + FRAC_BITS;   // slope magnitude width
    localparam int S  = P + 1;            // sum width before saturation
    localparam int K  = 7 + FRAC_BITS;    // shift from position to half degrees
    localparam int CW = $clog2(S);

    localparam logic [CW-1:0] CNT_P    = CW'(P);
    localparam logic [CW-1:0] CNT_Q    = CW'(Q);
    localparam logic [CW-1:0] CNT_LAST = CW'(S - 1);
    localparam logic [P-1:0]  POS_LIM  = {2'b01, {(P-2){1'b0}}};
    localparam logic [P-1:0]  NEG_LIM  = {2'b11, {(P-2){1'b0}}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_WB,
        ST_DIV
    } state_t;

    state_t               state_reg;
    logic [CW-1:0]        cnt_reg;
    logic [P-1:0]         pos_x_reg, pos_y_reg;
    logic [Q-1:0]         mag_x_reg, mag_y_reg;
    logic                 neg_x_reg, neg_y_reg;
    logic signed [15:0]   goal_x_reg, goal_y_reg;
    logic [S-1:0]         sum_x_reg, sum_y_reg;
    logic                 cx_reg, cy_reg;
    logic                 out_valid_reg;
    logic [11:0]          pulse_x_reg, pulse_y_reg;

    logic                 accept;
    logic                 wb_fire;
    logic                 div_start;
    logic                 div_x_busy, div_y_busy;
    logic [Q-1:0]         quo_x, quo_y;
    logic [16:0]          diff_x, diff_y;
    logic [16:0]          abs_x, abs_y;
    logic [DIVISOR_W-1:0] ticks_eff;
    logic [Q-1:0]         dvd_x, dvd_y;

    logic                 a_x, b_x, ci_x, s_x, co_x;
    logic                 a_y, b_y, ci_y, s_y, co_y;
    logic [P-1:0]         sat_x, sat_y;

    function automatic logic [P-1:0] saturate(input logic [S-1:0] s);
        logic pos_ovf;
        logic neg_ovf;
        pos_ovf = !s[S-1] && (s[P-1] || (s[P-2] && (|s[P-3:0])));
        neg_ovf = s[S-1] && !(&s[S-1:P-2]);
        if (pos_ovf)
            return POS_LIM;
        else if (neg_ovf)
            return NEG_LIM;
        else
            return s[P-1:0];
    endfunction

    // Pulse = 1920 + floor(-pos / 2^K), written as 1920 - floor(pos / 2^K) minus
    // one when any of the dropped bits is set.
    function automatic logic [11:0] pulse_of(input logic [P-1:0] p);
        logic [P-K-1:0] hi;
        logic           lo_nz;
        hi    = p[P-1:K];
        lo_nz = |p[K-1:0];
        return PULSE_CENTER - {{(12-(P-K)){hi[P-K-1]}}, hi} - {11'd0, lo_nz};
    endfunction

    assign accept    = in_valid && in_ready;
    assign in_ready  = state_reg == ST_IDLE;
    assign div_start = accept && (op_t'(opcode) == OP_SETPOINT);
    assign wb_fire   = (state_reg == ST_WB) && (!out_valid_reg || out_ready);

    // Slope magnitude and sign; the sign is applied later by the serial adder.
    assign diff_x    = {target_x[15], target_x} - {goal_x_reg[15], goal_x_reg};
    assign diff_y    = {target_y[15], target_y} - {goal_y_reg[15], goal_y_reg};
    assign abs_x     = diff_x[16] ? (17'd0 - diff_x) : diff_x;
    assign abs_y     = diff_y[16] ? (17'd0 - diff_y) : diff_y;
    assign dvd_x     = {abs_x[15:0], {FRAC_BITS{1'b0}}};
    assign dvd_y     = {abs_y[15:0], {FRAC_BITS{1'b0}}};
    assign ticks_eff = (frame_ticks == '0) ? DIVISOR_W'(1) : frame_ticks;

    srp_div #(
        .DW (Q)
    ) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd_x),
        .divisor  (ticks_eff),
        .busy     (div_x_busy),
        .quotient (quo_x)
    );

    srp_div #(
        .DW (Q)
    ) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd_y),
        .divisor  (ticks_eff),
        .busy     (div_y_busy),
        .quotient (quo_y)
    );

    // Bit-serial adders, least significant bit first. A negative slope is added
    // as its inverted magnitude with a carry of one into the first bit.
    assign a_x  = (cnt_reg < CNT_P) ? pos_x_reg[0] : pos_x_reg[P-1];
    assign b_x  = ((cnt_reg < CNT_Q) ? mag_x_reg[0] : 1'b0) ^ neg_x_reg;
    assign ci_x = (cnt_reg == '0) ? neg_x_reg : cx_reg;
    assign s_x  = a_x ^ b_x ^ ci_x;
    assign co_x = (a_x & b_x) | (a_x & ci_x) | (b_x & ci_x);

    assign a_y  = (cnt_reg < CNT_P) ? pos_y_reg[0] : pos_y_reg[P-1];
    assign b_y  = ((cnt_reg < CNT_Q) ? mag_y_reg[0] : 1'b0) ^ neg_y_reg;
    assign ci_y = (cnt_reg == '0) ? neg_y_reg : cy_reg;
    assign s_y  = a_y ^ b_y ^ ci_y;
    assign co_y = (a_y & b_y) | (a_y & ci_y) | (b_y & ci_y);

    assign sat_x = saturate(sum_x_reg);
    assign sat_y = saturate(sum_y_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            mag_x_reg     <= '0;
            mag_y_reg     <= '0;
            neg_x_reg     <= 1'b0;
            neg_y_reg     <= 1'b0;
            goal_x_reg    <= '0;
            goal_y_reg    <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            cx_reg        <= 1'b0;
            cy_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            pulse_x_reg   <= '0;
            pulse_y_reg   <= '0;
        end
        else
        begin
            if (wb_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cnt_reg <= '0;
                        if (op_t'(opcode) == OP_SETPOINT)
                        begin
                            pos_x_reg  <= {goal_x_reg[15], goal_x_reg, {FRAC_BITS{1'b0}}};
                            pos_y_reg  <= {goal_y_reg[15], goal_y_reg, {FRAC_BITS{1'b0}}};
                            neg_x_reg  <= diff_x[16];
                            neg_y_reg  <= diff_y[16];
                            goal_x_reg <= target_x;
                            goal_y_reg <= target_y;
                            state_reg  <= ST_DIV;
                        end
                        else
                        begin
                            state_reg <= ST_ADD;
                        end
                    end
                end

                ST_ADD:
                begin
                    sum_x_reg <= {s_x, sum_x_reg[S-1:1]};
                    sum_y_reg <= {s_y, sum_y_reg[S-1:1]};
                    cx_reg    <= co_x;
                    cy_reg    <= co_y;
                    // Both registers rotate back to their original value.
                    if (cnt_reg < CNT_P)
                    begin
                        pos_x_reg <= {pos_x_reg[0], pos_x_reg[P-1:1]};
                        pos_y_reg <= {pos_y_reg[0], pos_y_reg[P-1:1]};
                    end
                    if (cnt_reg < CNT_Q)
                    begin
                        mag_x_reg <= {mag_x_reg[0], mag_x_reg[Q-1:1]};
                        mag_y_reg <= {mag_y_reg[0], mag_y_reg[Q-1:1]};
                    end
                    if (cnt_reg == CNT_LAST)
                    begin
                        state_reg <= ST_WB;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end

                ST_WB:
                begin
                    if (wb_fire)
                    begin
                        pos_x_reg   <= sat_x;
                        pos_y_reg   <= sat_y;
                        pulse_x_reg <= pulse_of(sat_x);
                        pulse_y_reg <= pulse_of(sat_y);
                        state_reg   <= ST_IDLE;
                    end
                end

                ST_DIV:
                begin
                    if (!div_x_busy && !div_y_busy)
                    begin
                        mag_x_reg <= quo_x;
                        mag_y_reg <= quo_y;
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign pulse_x   = pulse_x_reg;
    assign pulse_y   = pulse_y_reg;

endmodule

### hdl/srp_div.sv
module srp_div #(
    parameter int DW = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [DW-1:0]                 dividend,
    input  logic [srp_pkg::DIVISOR_W-1:0] divisor,
    output logic                          busy,
    output logic [DW-1:0]                 quotient
);
    import srp_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0]        cnt_reg;
    logic [DW-1:0]        num_reg;
    logic [DW-1:0]        quo_reg;
    logic [DIVISOR_W-1:0] den_reg;
    logic [DIVISOR_W-1:0] rem_reg;

    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   trial_diff;
    logic                 fits;

    // Restoring division, one quotient bit per cycle, most significant first.
    // The remainder stays below the divisor, so it never needs more than DIVISOR_W bits.
    assign trial      = {rem_reg, num_reg[DW-1]};
    assign fits       = trial >= {1'b0, den_reg};
    assign trial_diff = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CW'(DW);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= fits ? trial_diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            num_reg <= {num_reg[DW-2:0], 1'b0};
            quo_reg <= {quo_reg[DW-2:0], fits};
        end
    end

    assign busy     = cnt_reg != '0;
    assign quotient = quo_reg;

endmodule

### test/servo_ramp_pwm_generator_unit_test.sv
module servo_ramp_pwm_generator_unit_test;

    import srp_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int POS_W = 17 + FB;
    localparam longint ANGLE_MAX = longint'(32768) << FB;
    localparam int RANDOM_ITEMS = 1925;
    localparam int ROWS = 25;

    typedef logic signed [POS_W-1:0] angle_t;

    typedef struct packed {
        logic [11:0] px;
        logic [11:0] py;
    } pulse_pair_t;

    typedef struct packed {
        op_t                op;
        logic signed [15:0] tx;
        logic signed [15:0] ty;
        logic [15:0]        ticks;
        logic               typed;
        logic [11:0]        ex;
        logic [11:0]        ey;
    } step_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               opcode = OP_TICK;
    logic signed [15:0] target_x = '0;
    logic signed [15:0] target_y = '0;
    logic [15:0]        frame_ticks = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [11:0]        pulse_x;
    logic [11:0]        pulse_y;

    // Predictor state of the servo ramp.
    angle_t             ramp_pos_x = '0;
    angle_t             ramp_pos_y = '0;
    angle_t             ramp_rate_x = '0;
    angle_t             ramp_rate_y = '0;
    logic signed [15:0] aim_x = '0;
    logic signed [15:0] aim_y = '0;

    pulse_pair_t        pending_pulses[$];
    int                 failures = 0;
    bit                 in_quiet = 1'b0;
    bit                 out_quiet = 1'b0;

    // Typed values are only on rows whose result is obvious: reset state,
    // full-scale steps and the saturated positions they lead to.
    step_row_t directed_rows [0:ROWS-1] = '{
        '{OP_TICK,     16'sd0,      16'sd0,      16'd0,     1'b1, 12'd1920, 12'd1920},
        '{OP_TICK,     16'sh7fff,   16'sh8000,   16'hffff,  1'b1, 12'd1920, 12'd1920},
        '{OP_SETPOINT, 16'sh7fff,   16'sh8000,   16'd1,     1'b0, 12'd0,    12'd0},
        '{OP_TICK,     16'sd0,      16'sd0,      16'd0,     1'b1, 12'd1664, 12'd2176},
        '{OP_TICK,     16'sd0,      16'sd0,      16'd0,     1'b1, 12'd1664, 12'd2176},
        '{OP_SETPOINT, 16'sh8000,   16'sh7fff,   16'd0,     1'b0, 12'd0,    12'd0},
        '{OP_TICK,     16'sd0,      16'sd0,      16'd0,     1'b1, 12'd2176, 12'd1664},
        '{OP_TICK,     16'sd0,      16'sd0,      16'd0,     1'b1, 12'd2176, 12'd1664},
        '{OP_SETPOINT, 16'sd0,      16'sd0,      16'd3,     1'b0, 12'd0,    12'd0},
        '{OP_TICK,     16'sd0,      16'sd0,      16'd0,     1'b0, 12'd0,    12'd0},
        '{OP_TICK,     16'sd0,      16'sd0,      16'd0,     1'b0, 12'd0,    12'd0},
        '{OP_TICK,     16'sd0,      16'sd0,      16'd0,     1'b0, 12'd0,    12'd0},
        '{OP_TICK,     16'sd0,      16'sd0,      16'd0,     1'b0, 12'd0,    12'd0},
        '{OP_SETPOINT, -16'sd1,     16'sd1,      16'd7,     1'b0, 12'd0,    12'd0},
        '{OP_TICK,     16'sd0,      16'sd0,      16'd0,     1'b0, 12'd0,    12'd0},
        '{OP_TICK,     16'sd0,      16'sd0,      16'd0,     1'b0, 12'd0,    12'd0},
        '{OP_SETPOINT, 16'sd256,    -16'sd256,   16'hffff,  1'b0, 12'd0,    12'd0},
        '{OP_TICK,     16'sd0,      16'sd0,      16'd0,     1'b0, 12'd0,    12'd0},
        '{OP_TICK,     16'sd0,      16'sd0,      16'd0,     1'b0, 12'd0,    12'd0},
        '{OP_SETPOINT, 16'sd100,    -16'sd100,   16'd2,     1'b0, 12'd0,    12'd0},
        '{OP_SETPOINT, -16'sd5000,  16'sd3000,   16'd4,     1'b0, 12'd0,    12'd0},
        '{OP_TICK,     16'sd0,      16'sd0,      16'd0,     1'b0, 12'd0,    12'd0},
        '{OP_TICK,     16'sd0,      16'sd0,      16'd0,     1'b0, 12'd0,    12'd0},
        '{OP_TICK,     16'sd0,      16'sd0,      16'd0,     1'b0, 12'd0,    12'd0},
        '{OP_TICK,     16'sh8000,   16'sh7fff,   16'h8000,  1'b0, 12'd0,    12'd0}
    };

    servo_ramp_pwm_generator_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .target_x    (target_x),
        .target_y    (target_y),
        .frame_ticks (frame_ticks),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pulse_x     (pulse_x),
        .pulse_y     (pulse_y)
    );

    always #4 clk = ~clk;

    function automatic logic [11:0] servo_pulse(angle_t pos);
        longint v;
        v = longint'(PULSE_CENTER) * 128 * (longint'(1) << FB) - longint'(pos);
        return 12'(v >>> (7 + FB));
    endfunction

    function automatic angle_t ramp_advance(angle_t pos, angle_t rate);
        longint n;
        n = longint'(pos) + longint'(rate);
        if (n > ANGLE_MAX)
            n = ANGLE_MAX;
        if (n < -ANGLE_MAX)
            n = -ANGLE_MAX;
        return angle_t'(n);
    endfunction

    // Truncating signed division, as the ramp slope is rounded toward zero.
    function automatic angle_t ramp_rate(logic signed [15:0] from, logic signed [15:0] to,
                                         logic [15:0] ticks);
        longint diff;
        longint div;
        diff = longint'(to) - longint'(from);
        div = (ticks == 16'd0) ? 64'sd1 : longint'({48'd0, ticks});
        return angle_t'((diff <<< FB) / div);
    endfunction

    task automatic predict_request(input op_t op, input logic signed [15:0] tx,
                                   input logic signed [15:0] ty, input logic [15:0] ticks,
                                   output logic has_pulse, output pulse_pair_t pp);
        if (op == OP_SETPOINT)
        begin
            ramp_pos_x = angle_t'(longint'(aim_x) <<< FB);
            ramp_pos_y = angle_t'(longint'(aim_y) <<< FB);
            ramp_rate_x = ramp_rate(aim_x, tx, ticks);
            ramp_rate_y = ramp_rate(aim_y, ty, ticks);
            aim_x = tx;
            aim_y = ty;
            has_pulse = 1'b0;
            pp = '0;
        end
        else
        begin
            ramp_pos_x = ramp_advance(ramp_pos_x, ramp_rate_x);
            ramp_pos_y = ramp_advance(ramp_pos_y, ramp_rate_y);
            has_pulse = 1'b1;
            pp.px = servo_pulse(ramp_pos_x);
            pp.py = servo_pulse(ramp_pos_y);
        end
    endtask

    task automatic send_request(input op_t op, input logic signed [15:0] tx,
                                input logic signed [15:0] ty, input logic [15:0] ticks,
                                input logic typed, input logic [11:0] ex, input logic [11:0] ey);
        int          gap;
        logic        has_pulse;
        pulse_pair_t pp;
        gap = in_quiet ? 0 : $urandom_range(0, 19);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        target_x <= tx;
        target_y <= ty;
        frame_ticks <= ticks;
        do
            @(posedge clk);
        while (!in_ready);
        predict_request(op, tx, ty, ticks, has_pulse, pp);
        if (has_pulse)
        begin
            if (typed)
                pp = '{px: ex, py: ey};
            pending_pulses.push_back(pp);
        end
    endtask

    initial
    begin
        op_t                op;
        logic signed [15:0] tx;
        logic signed [15:0] ty;
        logic [15:0]        ticks;
        int                 pick;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < ROWS; i++)
            send_request(directed_rows[i].op, directed_rows[i].tx, directed_rows[i].ty,
                         directed_rows[i].ticks, directed_rows[i].typed,
                         directed_rows[i].ex, directed_rows[i].ey);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 64 == 0)
                in_quiet = ($urandom_range(0, 3) == 0);
            tx = 16'($urandom);
            ty = 16'($urandom);
            ticks = 16'($urandom);
            op = ($urandom_range(0, 11) == 0) ? OP_SETPOINT : OP_TICK;
            if (op == OP_SETPOINT)
            begin
                // Full-scale targets drive the ramp into saturation.
                pick = $urandom_range(0, 7);
                if (pick == 0)
                    tx = 16'sh7fff;
                else if (pick == 1)
                    tx = 16'sh8000;
                pick = $urandom_range(0, 7);
                if (pick == 0)
                    ty = 16'sh8000;
                else if (pick == 1)
                    ty = 16'sh7fff;
                // Mostly short frames so that the ramp overshoots between setpoints.
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    ticks = 16'd0;
                else if (pick == 1)
                    ticks = 16'hffff;
                else if (pick > 3)
                    ticks = 16'($urandom_range(1, 60));
            end
            send_request(op, tx, ty, ticks, 1'b0, 12'd0, 12'd0);
        end
        in_valid <= 1'b0;
        while (pending_pulses.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        int          gap;
        int          count;
        pulse_pair_t want;
        count = 0;
        forever
        begin
            if (count % 64 == 0)
                out_quiet = ($urandom_range(0, 3) == 0);
            count++;
            gap = out_quiet ? 0 : $urandom_range(0, 19);
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            if (pending_pulses.size() == 0)
            begin
                $display("%0t unrequested result pulse_x %0d pulse_y %0d",
                         $time, pulse_x, pulse_y);
                failures++;
            end
            else
            begin
                want = pending_pulses.pop_front();
                if (pulse_x !== want.px)
                begin
                    $display("%0t pulse_x expected %0d actual %0d", $time, want.px, pulse_x);
                    failures++;
                end
                if (pulse_y !== want.py)
                begin
                    $display("%0t pulse_y expected %0d actual %0d", $time, want.py, pulse_y);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        #8000000;
        $display("FAIL");
        $finish;
    end

endmodule
